// ===== rtl/sasc_pkg.sv =====
// Shared widths, codes, constants and interface types of the stepper angle step controller.
package sasc_pkg;

  localparam int OP_W       = 3;
  localparam int VAL_W      = 16;
  localparam int TOP_W      = 16;
  localparam int ANG_W      = 17;
  localparam int ADC_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MS_W       = 5;
  localparam int SPR_W      = 10;
  localparam int SPD_W      = 10;
  localparam int ALIM_W     = 10;
  localparam int OFS_W      = 16;
  localparam int PROD1_W    = 20;

  // Half-period divider: 60 * 16 MHz over the prescaler product.
  localparam int DIV_N_W   = 30;
  localparam int DIV_D_W   = 28;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_N_W-1:0] CLK_SIXTY_PRE = 30'd960000000;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_SET_SPEED  = 3'd0;
  localparam op_t OP_SET_TARGET = 3'd1;
  localparam op_t OP_POT        = 3'd2;
  localparam op_t OP_TICK       = 3'd3;
  localparam op_t OP_HOME       = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MICROSTEP  = 3'd0;
  localparam cfg_idx_t CFG_STEPS_REV  = 3'd1;
  localparam cfg_idx_t CFG_SPEED_LOW  = 3'd2;
  localparam cfg_idx_t CFG_SPEED_HIGH = 3'd3;
  localparam cfg_idx_t CFG_ANGLE_LOW  = 3'd4;
  localparam cfg_idx_t CFG_ANGLE_HIGH = 3'd5;
  localparam cfg_idx_t CFG_OFFSET     = 3'd6;
  localparam cfg_idx_t CFG_REVERSE    = 3'd7;

  localparam logic [MS_W-1:0]   MS_RST     = 5'd1;
  localparam logic [SPR_W-1:0]  SPR_RST    = 10'd200;
  localparam logic [SPD_W-1:0]  SPD_LO_RST = 10'd1;
  localparam logic [SPD_W-1:0]  SPD_HI_RST = 10'd300;
  localparam logic [ALIM_W-1:0] ALO_RST    = 10'd0;
  localparam logic [ALIM_W-1:0] AHI_RST    = 10'd300;
  localparam logic [OFS_W-1:0]  OFS_RST    = 16'd0;

  localparam logic signed [ANG_W-1:0] HOME_RPM  = 17'sd10;
  localparam logic signed [ANG_W:0]   TOLERANCE = 18'sd64;

  // Pot conversion: round(adc*19200/1023) = (adc*38400 + 1023) / 2046,
  // estimated with a 2^32 reciprocal of 2046 and fixed by one compare.
  localparam int POT_N_W = 26;
  localparam int POT_P_W = 48;
  localparam int POT_Q_W = 15;
  localparam logic [POT_N_W-1:0] ADC_SCALE = 26'd38400;
  localparam logic [POT_N_W-1:0] ADC_ROUND = 26'd1023;
  localparam logic [POT_N_W-1:0] ADC_DIV   = 26'd2046;
  localparam logic [POT_P_W-1:0] POT_KA    = 48'd80609356800;
  localparam logic [POT_P_W-1:0] POT_KB    = 48'd2147483646;

  typedef struct packed {
    logic load_in;
    logic spd_mul1;
    logic spd_mul2;
    logic div_start;
    logic spd_wr;
    logic tgt_wr;
    logic home_wr;
    logic pot_mul;
    logic pot_wr;
    logic tick_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic spd_skip;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/sasc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the step half-period.
module sasc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sasc_pkg::DIV_N_W-1:0] dividend,
  input  logic [sasc_pkg::DIV_D_W-1:0] divisor,
  output logic [sasc_pkg::DIV_N_W-1:0] quotient,
  output logic                         done
);
  import sasc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
`endif

endmodule

// ===== rtl/sasc_dp.sv =====
// Datapath: configuration, controller state, speed and angle arithmetic, result register.
module sasc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sasc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sasc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [sasc_pkg::OP_W-1:0]         in_op,
  input  logic signed [sasc_pkg::VAL_W-1:0] in_value,
  input  sasc_pkg::cmd_t                    cmd,
  output sasc_pkg::sts_t                    sts,
  output logic                              out_step_level,
  output logic                              out_direction,
  output logic                              out_running,
  output logic [sasc_pkg::TOP_W-1:0]        out_half_period,
  output logic signed [sasc_pkg::ANG_W-1:0] out_measured_angle,
  output logic                              out_accepted
);
  import sasc_pkg::*;

  // configuration
  logic [MS_W-1:0]   ms_r;
  logic [SPR_W-1:0]  spr_r;
  logic [SPD_W-1:0]  spd_lo_r, spd_hi_r;
  logic [ALIM_W-1:0] alo_r, ahi_r;
  logic [OFS_W-1:0]  ofs_r;
  logic              rev_r;

  // controller state
  logic                    run_r, run_nxt;
  logic                    pulse_r, pulse_nxt;
  logic [TOP_W-1:0]        tick_r, tick_nxt;
  logic [TOP_W-1:0]        top_r, top_nxt;
  logic signed [ANG_W-1:0] tgt_r, tgt_nxt;
  logic signed [ANG_W-1:0] last_r, last_nxt;
  logic                    dir_r, dir_nxt;

  // per-item working registers
  op_t                  op_r;
  logic [VAL_W-1:0]     val_r;
  logic                 acc_r, acc_nxt;
  logic                 range_ok_r;
  logic [PROD1_W-1:0]   prod1_r;
  logic [DIV_D_W-1:0]   d_r;
  logic [POT_Q_W-1:0]   q0_r;

  logic signed [ANG_W-1:0] rpm_s;
  logic                    in_range;
  logic [DIV_N_W-1:0]      quo;
  logic                    div_done;
  logic [DIV_N_W-1:0]      quo_m1;
  logic [TOP_W-1:0]        top_sat;
  logic signed [ANG_W-1:0] val17, lo64, hi64;
  logic                    tgt_ok;
  logic [POT_P_W-1:0]      pot_prod;
  logic [POT_N_W-1:0]      pot_n, pot_r;
  logic [POT_Q_W-1:0]      pot_q;
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W:0]   err;

  // Speed: rpm is the command value, or the fixed homing speed.
  assign rpm_s    = (op_r == OP_HOME) ? HOME_RPM : {val_r[VAL_W-1], val_r};
  assign in_range = (rpm_s >= $signed({7'b0, spd_lo_r})) &&
                    (rpm_s <= $signed({7'b0, spd_hi_r}));

  sasc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (CLK_SIXTY_PRE),
    .divisor  (d_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign quo_m1  = (quo == '0) ? '0 : (quo - 1'b1) >> 2;
  assign top_sat = (|quo_m1[DIV_N_W-1:TOP_W]) ? {TOP_W{1'b1}} : quo_m1[TOP_W-1:0];

  // Target bounds in 1/64 degree.
  assign val17  = {val_r[VAL_W-1], val_r};
  assign lo64   = {alo_r[ALIM_W-1], alo_r, 6'b0};
  assign hi64   = {ahi_r[ALIM_W-1], ahi_r, 6'b0};
  assign tgt_ok = (val17 >= lo64) && (val17 <= hi64);

  // Pot: reciprocal estimate, then one correction step.
  assign pot_prod = POT_P_W'(val_r[ADC_W-1:0]) * POT_KA + POT_KB;
  assign pot_n    = POT_N_W'(val_r[ADC_W-1:0]) * ADC_SCALE + ADC_ROUND;
  assign pot_r    = pot_n - POT_N_W'(q0_r) * ADC_DIV;
  assign pot_q    = (pot_r >= ADC_DIV) ? q0_r + 1'b1 : q0_r;
  assign ang      = $signed({2'b00, pot_q}) - $signed({ofs_r[OFS_W-1], ofs_r});
  assign err      = {ang[ANG_W-1], ang} - {tgt_r[ANG_W-1], tgt_r};

  always_comb begin
    run_nxt   = run_r;
    pulse_nxt = pulse_r;
    tick_nxt  = tick_r;
    top_nxt   = top_r;
    tgt_nxt   = tgt_r;
    last_nxt  = last_r;
    dir_nxt   = dir_r;
    acc_nxt   = acc_r;
    if (cmd.load_in) begin
      acc_nxt = 1'b0;
    end
    if (cmd.home_wr) begin
      tgt_nxt  = '0;
      tick_nxt = '0;
      run_nxt  = 1'b1;
    end
    if (cmd.spd_wr) begin
      top_nxt = (range_ok_r && (d_r != '0)) ? top_sat : '0;
      acc_nxt = range_ok_r;
    end
    if (cmd.tgt_wr && tgt_ok) begin
      tgt_nxt = val17;
      run_nxt = 1'b1;
      acc_nxt = 1'b1;
    end
    if (cmd.pot_wr) begin
      last_nxt = ang;
      dir_nxt  = (tgt_r > ang) ^ rev_r;
      if ((err >= -TOLERANCE) && (err <= TOLERANCE)) begin
        run_nxt = 1'b0;
      end
    end
    if (cmd.tick_wr && run_r && (top_r != '0)) begin
      if (tick_r >= top_r) begin
        tick_nxt  = '0;
        pulse_nxt = ~pulse_r;
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r     <= MS_RST;
      spr_r    <= SPR_RST;
      spd_lo_r <= SPD_LO_RST;
      spd_hi_r <= SPD_HI_RST;
      alo_r    <= ALO_RST;
      ahi_r    <= AHI_RST;
      ofs_r    <= OFS_RST;
      rev_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MICROSTEP:  ms_r     <= cfg_data[MS_W-1:0];
        CFG_STEPS_REV:  spr_r    <= cfg_data[SPR_W-1:0];
        CFG_SPEED_LOW:  spd_lo_r <= cfg_data[SPD_W-1:0];
        CFG_SPEED_HIGH: spd_hi_r <= cfg_data[SPD_W-1:0];
        CFG_ANGLE_LOW:  alo_r    <= cfg_data[ALIM_W-1:0];
        CFG_ANGLE_HIGH: ahi_r    <= cfg_data[ALIM_W-1:0];
        CFG_OFFSET:     ofs_r    <= cfg_data[OFS_W-1:0];
        CFG_REVERSE:    rev_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      pulse_r <= 1'b0;
      tick_r  <= '0;
      top_r   <= '0;
      tgt_r   <= '0;
      last_r  <= '0;
      dir_r   <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      pulse_r <= pulse_nxt;
      tick_r  <= tick_nxt;
      top_r   <= top_nxt;
      tgt_r   <= tgt_nxt;
      last_r  <= last_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load_in) begin
      op_r  <= in_op;
      val_r <= in_value;
    end
    if (cmd.spd_mul1) begin
      range_ok_r <= in_range;
      prod1_r    <= PROD1_W'(rpm_s[SPD_W-1:0]) * PROD1_W'(spr_r);
    end
    if (cmd.spd_mul2) begin
      d_r <= {25'(prod1_r) * 25'(ms_r), 3'b000};
    end
    if (cmd.pot_mul) begin
      q0_r <= pot_prod[POT_Q_W+31:32];
    end
    if (cmd.out_load) begin
      out_step_level     <= pulse_r;
      out_direction      <= dir_r;
      out_running        <= run_r;
      out_half_period    <= top_r;
      out_measured_angle <= last_r;
      out_accepted       <= acc_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.spd_skip = !range_ok_r || (d_r == '0);
  assign sts.div_done = div_done;

endmodule

// ===== rtl/sasc_ctrl.sv =====
// Sequencer: steps each command through the datapath and hands off the result beat.
module sasc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sasc_pkg::sts_t sts,
  output sasc_pkg::cmd_t cmd
);
  import sasc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_POTC = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_SET_SPEED: begin
            cmd.spd_mul1 = 1'b1;
            state_nxt    = S_MUL2;
          end
          OP_HOME: begin
            cmd.home_wr  = 1'b1;
            cmd.spd_mul1 = 1'b1;
            state_nxt    = S_MUL2;
          end
          OP_SET_TARGET: begin
            cmd.tgt_wr = 1'b1;
            state_nxt  = S_DONE;
          end
          OP_POT: begin
            cmd.pot_mul = 1'b1;
            state_nxt   = S_POTC;
          end
          OP_TICK: begin
            cmd.tick_wr = 1'b1;
            state_nxt   = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL2: begin
        cmd.spd_mul2 = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (sts.spd_skip) begin
          cmd.spd_wr = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.spd_wr = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_POTC: begin
        cmd.pot_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_hold_waiting_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result overwritten while the previous beat was stalled");
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the hand-off state");
  a_div_only_for_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (sts.op == OP_SET_SPEED || sts.op == OP_HOME))
    else $error("divider wait entered for a non-speed command");
`endif

endmodule

// ===== rtl/stepper_angle_step_controller_core.sv =====
// Top level of the constant-speed stepper angle step controller.
//
// Usage: each input beat (in_op, in_value) is one command: set speed in rpm,
// set target angle in 1/64 degree, pot sample (ADC code in the low 10 bits),
// timer tick, or home. Every command returns exactly one result beat with
// the step and direction line levels, the running flag, the half-period
// (timer top, 0 = halted), the last measured angle and the accepted flag.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The result sits in an output register, so the next command is
// taken while a finished result still waits downstream.
// Steps: a tick, target or unused code executes, then hands off; a pot sample
// gets a reciprocal multiply, then a correction; a speed or home command gets
// two multiplies, a range check and, unless out of range or zero, the 30-step
// one-bit-per-cycle divider that forms the half-period. One command is in the
// sequencer at a time. When the receiver stalls, the finished result holds
// and the sequencer waits in hand-off; in_stall stays high until it is taken.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the run, step, direction, counter, target and angle state.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// makes them only while no command is in flight, not enforced by the block.
module stepper_angle_step_controller_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sasc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sasc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sasc_pkg::OP_W-1:0]         in_op,
  input  logic signed [sasc_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_step_level,
  output logic                              out_direction,
  output logic                              out_running,
  output logic [sasc_pkg::TOP_W-1:0]        out_half_period,
  output logic signed [sasc_pkg::ANG_W-1:0] out_measured_angle,
  output logic                              out_accepted
);
  import sasc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks each command through its datapath steps.
  sasc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: registers, multipliers, divider and the result register.
  sasc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_op              (in_op),
    .in_value           (in_value),
    .cmd                (cmd),
    .sts                (sts),
    .out_step_level     (out_step_level),
    .out_direction      (out_direction),
    .out_running        (out_running),
    .out_half_period    (out_half_period),
    .out_measured_angle (out_measured_angle),
    .out_accepted       (out_accepted)
  );

endmodule
